FILE: hw/rtl/ipdq_pkg.sv
// ============================================================================
// IPv4 dotted-quad parser package
// Shared result codes, character constants and the per-item result record.
// ============================================================================
`default_nettype none

package ipdq_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_RESERVED  = 2'd3
    } t_status;

    // Character codes of interest.
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Octet limits and dot counting.
    localparam logic [8:0] OCTET_MAX   = 9'd255;
    localparam logic [8:0] OCTET_SAT   = 9'd256;
    localparam logic [2:0] DOTS_NEEDED = 3'd3;
    localparam logic [2:0] DOT_SAT     = 3'd4;

    // Reserved address ranges.
    localparam logic [7:0] OCTET_NONE     = 8'd0;
    localparam logic [7:0] RESERVED_ABOVE = 8'd223;
    localparam logic [7:0] LOOPBACK_OCTET = 8'd127;
    localparam logic [7:0] BCAST_OCTET    = 8'd255;

    // One finished result, handed from the parser to the output stage.
    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [31:0] address;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/ipdq_in_if.sv
// ============================================================================
// Character input channel
// Valid/ready channel that carries one byte of address text per transfer.
// ============================================================================
`default_nettype none

interface ipdq_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       has_char;
    logic       last;

    modport source (output valid, output character, output has_char, output last,
                    input ready);
    modport sink   (input valid, input character, input has_char, input last,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ipdq_out_if.sv
// ============================================================================
// Result output channel
// Valid/ready channel that carries one parse status and address per transfer.
// ============================================================================
`default_nettype none

interface ipdq_out_if;
    logic             valid;
    logic             ready;
    ipdq_pkg::t_status status;
    logic [31:0]      address;

    modport source (output valid, output status, output address, input ready);
    modport sink   (input valid, input status, input address, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ipdq_step.sv
// ============================================================================
// IPv4 dotted-quad parser step
// Per-character parse state update and end-of-string result evaluation.
// ============================================================================
`default_nettype none

module ipdq_step (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_character,
    input  wire logic             i_has_char,
    input  wire logic             i_last,
    output ipdq_pkg::t_result     o_res
);

    logic [8:0]  r_acc,       n_acc;
    logic [2:0]  r_dot_count, n_dot_count;
    logic [23:0] r_high,      n_high;
    logic        r_digits,    n_digits;
    logic        r_prev_dot,  n_prev_dot;
    logic        r_blank,     n_blank;
    logic        r_nonblank,  n_nonblank;
    logic        r_bad,       n_bad;

    logic        w_is_blank;
    logic        w_is_digit;
    logic [11:0] w_acc_sum;
    logic [7:0]  w_first;
    logic [7:0]  w_lastoct;

    // Decimal accumulate: acc * 10 + digit, as two shifts and adds.
    assign w_acc_sum = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + {8'd0, i_character[3:0]};

    always_comb begin
        w_is_blank = (i_character == ipdq_pkg::CHAR_SPACE) ||
                     (i_character == ipdq_pkg::CHAR_TAB);
        w_is_digit = i_character inside {[ipdq_pkg::CHAR_ZERO:ipdq_pkg::CHAR_NINE]};

        n_acc       = r_acc;
        n_dot_count = r_dot_count;
        n_high      = r_high;
        n_digits    = r_digits;
        n_prev_dot  = r_prev_dot;
        n_blank     = r_blank;
        n_nonblank  = r_nonblank;
        n_bad       = r_bad;

        if (i_has_char) begin
            if (w_is_blank) begin
                n_blank    = 1'b1;
                n_prev_dot = 1'b0;
            end else begin
                n_nonblank = 1'b1;
                if (w_is_digit) begin
                    n_acc      = (w_acc_sum > {3'b000, ipdq_pkg::OCTET_SAT}) ?
                                 ipdq_pkg::OCTET_SAT : w_acc_sum[8:0];
                    n_digits   = 1'b1;
                    n_prev_dot = 1'b0;
                end else if (i_character == ipdq_pkg::CHAR_DOT) begin
                    if (r_prev_dot || (r_acc > ipdq_pkg::OCTET_MAX)) begin
                        n_bad = 1'b1;
                    end
                    if (r_dot_count < ipdq_pkg::DOTS_NEEDED) begin
                        n_high = {r_high[15:0], r_acc[7:0]};
                    end
                    if (r_dot_count < ipdq_pkg::DOT_SAT) begin
                        n_dot_count = r_dot_count + 3'd1;
                    end
                    n_acc      = '0;
                    n_digits   = 1'b0;
                    n_prev_dot = 1'b1;
                end else begin
                    n_bad      = 1'b1;
                    n_prev_dot = 1'b0;
                end
            end
        end

        // Evaluate the string as it stands after this character.
        w_first       = n_high[23:16];
        w_lastoct     = n_acc[7:0];
        o_res.valid   = i_accept && i_last;
        o_res.address = '0;
        if (!n_nonblank) begin
            o_res.status = ipdq_pkg::ST_EMPTY;
        end else if (n_blank || n_bad || (n_dot_count != ipdq_pkg::DOTS_NEEDED) ||
                     !n_digits || (n_acc > ipdq_pkg::OCTET_MAX)) begin
            o_res.status = ipdq_pkg::ST_MALFORMED;
        end else begin
            o_res.address = {n_high, w_lastoct};
            if ((w_first == ipdq_pkg::OCTET_NONE) || (w_first > ipdq_pkg::RESERVED_ABOVE) ||
                (w_first == ipdq_pkg::LOOPBACK_OCTET) || (w_lastoct == ipdq_pkg::BCAST_OCTET)) begin
                o_res.status = ipdq_pkg::ST_RESERVED;
            end else begin
                o_res.status = ipdq_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_acc       <= '0;
            r_dot_count <= '0;
            r_high      <= '0;
            r_digits    <= 1'b0;
            r_prev_dot  <= 1'b0;
            r_blank     <= 1'b0;
            r_nonblank  <= 1'b0;
            r_bad       <= 1'b0;
        end else if (i_accept) begin
            r_acc       <= n_acc;
            r_dot_count <= n_dot_count;
            r_high      <= n_high;
            r_digits    <= n_digits;
            r_prev_dot  <= n_prev_dot;
            r_blank     <= n_blank;
            r_nonblank  <= n_nonblank;
            r_bad       <= n_bad;
        end
    end

    // The dot counter saturates and never passes its ceiling.
    a_dot_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot_count <= ipdq_pkg::DOT_SAT)
        else $error("dot counter beyond saturation");

    // The end of a string leaves a clean parse state for the next one.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_dot_count == '0 && !r_nonblank && !r_bad && r_acc == '0))
        else $error("parse state not cleared after end of string");

    // A digit ends a dot run, and a dot empties the octet.
    a_digit_dot_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_digits && r_prev_dot))
        else $error("octet holds digits directly after a dot");

endmodule

`default_nettype wire

FILE: hw/rtl/ipdq_skid.sv
// ============================================================================
// IPv4 dotted-quad parser output stage
// Output register plus one skid entry so parsing continues during a stall.
// ============================================================================
`default_nettype none

module ipdq_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ipdq_pkg::t_result i_res,
    output logic                   o_in_ready,
    ipdq_out_if.source             o_out
);

    logic              r_out_valid,  n_out_valid;
    ipdq_pkg::t_status r_out_status, n_out_status;
    logic [31:0]       r_out_addr,   n_out_addr;
    logic              r_skid_valid, n_skid_valid;
    ipdq_pkg::t_status r_skid_status, n_skid_status;
    logic [31:0]       r_skid_addr,  n_skid_addr;

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_addr    = r_out_addr;
        n_skid_valid  = r_skid_valid;
        n_skid_status = r_skid_status;
        n_skid_addr   = r_skid_addr;

        if (r_skid_valid) begin
            if (o_out.ready) begin
                n_out_status = r_skid_status;
                n_out_addr   = r_skid_addr;
                n_skid_valid = 1'b0;
            end
        end else if (i_res.valid) begin
            if (!r_out_valid || o_out.ready) begin
                n_out_valid  = 1'b1;
                n_out_status = i_res.status;
                n_out_addr   = i_res.address;
            end else begin
                n_skid_valid  = 1'b1;
                n_skid_status = i_res.status;
                n_skid_addr   = i_res.address;
            end
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status  <= n_out_status;
        r_out_addr    <= n_out_addr;
        r_skid_status <= n_skid_status;
        r_skid_addr   <= n_skid_addr;
    end

    assign o_in_ready    = !r_skid_valid;
    assign o_out.valid   = r_out_valid;
    assign o_out.status  = r_out_status;
    assign o_out.address = r_out_addr;

    // The skid entry is only ever filled behind a held output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds data while output register is empty");

    // No new result arrives while the skid entry is occupied.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.valid |-> !r_skid_valid)
        else $error("result arrived with skid entry full");

    // A result that meets a stalled output register is parked in the skid entry.
    a_park_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res.valid && r_out_valid && !o_out.ready) |=> r_skid_valid)
        else $error("result lost during output stall");

    // Draining the skid entry keeps the output register full.
    a_drain_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && o_out.ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid drain did not refill output register");

endmodule

`default_nettype wire

FILE: hw/rtl/ipv4_dotted_quad_host_parser.sv
// ============================================================================
// IPv4 dotted-quad host address parser
// Streams address text one character per transfer and reports its status.
// ============================================================================
// Usage:
//   The input channel i_in carries one byte of address text per transfer,
//   with has_char marking a real character and last marking the end of the
//   string. An item with has_char low and last high ends an empty string.
//   On the transfer that carries last, the block produces one result on o_out:
//   a status (ok host, malformed, empty or blank, reserved) and the 32-bit
//   address with the first octet in bits 31..24 (zero unless ok or reserved).
// Throughput and result path:
//   One character is taken every cycle while i_in.ready is high. A string's
//   result is registered in the output register, or in the skid entry if
//   o_out stalls. The per-cycle work, the decimal accumulate (times ten plus
//   digit) and flag update, lies between the parse state and output registers.
// Reset:
//   A synchronous active-low reset clears the parse state and empties the
//   output stage. The parse state is also cleared after every string.
// Stalls:
//   When o_out is not ready, one result waits in the output register and a
//   second one in a skid entry; characters keep flowing until that skid entry
//   is filled, and only then does i_in.ready drop.
// ============================================================================
`default_nettype none

module ipv4_dotted_quad_host_parser (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ipdq_in_if.sink     i_in,
    ipdq_out_if.source  o_out
);

    // Input transfer strobe and the result record passed to the output stage.
    logic              w_in_ready;
    logic              w_accept;
    ipdq_pkg::t_result w_res;

    assign i_in.ready = w_in_ready;
    assign w_accept   = i_in.valid && w_in_ready;

    // Character-by-character parse state and end-of-string evaluation.
    ipdq_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_character (i_in.character),
        .i_has_char  (i_in.has_char),
        .i_last      (i_in.last),
        .o_res       (w_res)
    );

    // Output register with one skid entry; its fill level sets input ready.
    ipdq_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (w_res),
        .o_in_ready (w_in_ready),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

FILE: dv/ipv4_dotted_quad_host_parser_tb.sv
// ============================================================================
// IPv4 dotted-quad host parser testbench
// Streams address text into the parser one character per transfer and checks
// every status and address it reports against a cycle-free software parser.
// ============================================================================
`default_nettype none

module ipv4_dotted_quad_host_parser_tb;

    // One character transfer as the sender sees it.
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } t_char_item;

    // One parse outcome, in the same shape as the output channel payload.
    typedef struct packed {
        ipdq_pkg::t_status status;
        logic [31:0]       address;
    } t_parse_result;

    // The watchdog ends the run after this many cycles with no transfer on
    // either channel. The longest legal quiet stretch is the forced receiver
    // hold-off below, so this leaves ample margin.
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_ITEMS = 450;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ipdq_in_if  in_ch ();
    ipdq_out_if out_ch ();

    ipv4_dotted_quad_host_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Software parser state. It mirrors the block's parse registers and is
    // cleared after every string, exactly like the hardware.
    // ------------------------------------------------------------------------
    logic [8:0]  octet_val      = '0;
    logic [2:0]  dots           = '0;
    logic [23:0] upper_octets   = '0;
    logic        octet_has_digit = 1'b0;
    logic        after_dot      = 1'b0;
    logic        blank_seen     = 1'b0;
    logic        nonblank_seen  = 1'b0;
    logic        malformed      = 1'b0;

    // Stimulus and scoreboard storage.
    t_char_item    pending_chars[$];
    t_parse_result awaited_parses[$];
    logic [7:0]    text_buf[$];

    int unsigned counted_items = 0;
    int unsigned strings_built = 0;
    int unsigned chars_taken = 0;
    int unsigned results_seen = 0;
    int unsigned input_backpressure = 0;
    int unsigned mismatch_count = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};

    // Handshake bookkeeping for the sender, receiver, monitor and watchdog.
    logic          in_took = 1'b0;
    logic          long_hold;
    int unsigned   quiet_cycles = 0;
    int unsigned   burst_left = 1;
    int unsigned   gap_left = 0;
    int unsigned   rx_cycle = 0;
    int unsigned   rx_mode = 0;
    t_char_item    next_item;
    bit            parse_done;
    t_parse_result predicted;
    t_parse_result want;

    // ------------------------------------------------------------------------
    // Predictor: advance the software parser by one character transfer. When
    // the transfer closes a string, finished is set and res holds the outcome.
    // ------------------------------------------------------------------------
    task automatic parse_char(input t_char_item item, output bit finished,
                              output t_parse_result res);
        int unsigned grown;
        logic [7:0]  first_oct;
        logic [7:0]  last_oct;
        finished    = 1'b0;
        res.status  = ipdq_pkg::ST_EMPTY;
        res.address = '0;
        if (item.has_char) begin
            if (item.ch == ipdq_pkg::CHAR_SPACE || item.ch == ipdq_pkg::CHAR_TAB) begin
                // Blanks only matter at the end: alone they mean an empty
                // string, mixed with anything else they mean malformed.
                blank_seen = 1'b1;
                after_dot  = 1'b0;
            end else if (item.ch inside {[ipdq_pkg::CHAR_ZERO:ipdq_pkg::CHAR_NINE]}) begin
                // Decimal accumulate that saturates one above the octet range,
                // so any overflow stays visible until the next dot.
                nonblank_seen   = 1'b1;
                grown           = octet_val * 10 + (item.ch - ipdq_pkg::CHAR_ZERO);
                octet_val       = (grown > ipdq_pkg::OCTET_SAT) ? ipdq_pkg::OCTET_SAT
                                                                : grown[8:0];
                octet_has_digit = 1'b1;
                after_dot       = 1'b0;
            end else if (item.ch == ipdq_pkg::CHAR_DOT) begin
                nonblank_seen = 1'b1;
                if (after_dot || octet_val > ipdq_pkg::OCTET_MAX) begin
                    malformed = 1'b1;
                end
                // Only the first three octets shift into the upper bits; any
                // further dot is merely counted.
                if (dots < ipdq_pkg::DOTS_NEEDED) begin
                    upper_octets = {upper_octets[15:0], octet_val[7:0]};
                end
                if (dots < ipdq_pkg::DOT_SAT) begin
                    dots = dots + 3'd1;
                end
                octet_val       = '0;
                octet_has_digit = 1'b0;
                after_dot       = 1'b1;
            end else begin
                nonblank_seen = 1'b1;
                malformed     = 1'b1;
                after_dot     = 1'b0;
            end
        end
        if (item.last) begin
            finished = 1'b1;
            if (!nonblank_seen) begin
                res.status = ipdq_pkg::ST_EMPTY;
            end else if (blank_seen || malformed || dots != ipdq_pkg::DOTS_NEEDED ||
                         !octet_has_digit || octet_val > ipdq_pkg::OCTET_MAX) begin
                res.status = ipdq_pkg::ST_MALFORMED;
            end else begin
                first_oct   = upper_octets[23:16];
                last_oct    = octet_val[7:0];
                res.address = {upper_octets, last_oct};
                if (first_oct == ipdq_pkg::OCTET_NONE ||
                    first_oct > ipdq_pkg::RESERVED_ABOVE ||
                    first_oct == ipdq_pkg::LOOPBACK_OCTET ||
                    last_oct == ipdq_pkg::BCAST_OCTET) begin
                    res.status = ipdq_pkg::ST_RESERVED;
                end else begin
                    res.status = ipdq_pkg::ST_OK;
                end
            end
            octet_val       = '0;
            dots            = '0;
            upper_octets    = '0;
            octet_has_digit = 1'b0;
            after_dot       = 1'b0;
            blank_seen      = 1'b0;
            nonblank_seen   = 1'b0;
            malformed       = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] mismatch on result %0d, %s: got 0x%08h, expected 0x%08h",
                 $time, results_seen, what, got, exp_val);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders. Strings are assembled in text_buf and then queued as
    // transfers; every queued transfer counts toward the run length.
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [7:0] ch, input logic has, input logic fin);
        pending_chars.push_back(t_char_item'{ch, has, fin});
        counted_items++;
        if (fin) begin
            strings_built++;
        end
    endtask

    // Queue text_buf as one string. Ignored no-character transfers are
    // sprinkled in, and the string may be closed by a trailing transfer that
    // carries no character.
    task automatic send_text(input bit end_nochar);
        foreach (text_buf[i]) begin
            if ($urandom_range(0, 19) == 0) begin
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            push_item(text_buf[i], 1'b1, !end_nochar && i == text_buf.size() - 1);
        end
        if (end_nochar || text_buf.size() == 0) begin
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        text_buf.delete();
    endtask

    task automatic send_literal(input string s, input bit end_nochar);
        for (int i = 0; i < s.len(); i++) begin
            text_buf.push_back(s[i]);
        end
        send_text(end_nochar);
    endtask

    task automatic append_number(input int unsigned value, input int unsigned zeros);
        logic [7:0]  digits[$];
        int unsigned rest;
        rest = value;
        repeat (zeros) text_buf.push_back(ipdq_pkg::CHAR_ZERO);
        do begin
            digits.push_front(ipdq_pkg::CHAR_ZERO + 8'(rest % 10));
            rest = rest / 10;
        end while (rest != 0);
        foreach (digits[i]) begin
            text_buf.push_back(digits[i]);
        end
    endtask

    // A well-formed dotted quad with octets biased toward the reserved-range
    // boundaries. Now and then one octet overflows, carries long runs of
    // leading zeros, or the first octet is left empty.
    task automatic build_address();
        int unsigned val;
        int unsigned zeros;
        int unsigned wide_octet;
        wide_octet = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 3) : 4;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 9))
                0: val = 0;
                1: val = 127;
                2: val = 223;
                3: val = 224;
                4: val = 255;
                default: val = $urandom_range(0, 255);
            endcase
            if (k == wide_octet) begin
                val = $urandom_range(0, 1) ? $urandom_range(256, 999)
                                           : $urandom_range(1000, 99999);
            end
            zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            if ($urandom_range(0, 49) == 0) begin
                zeros = $urandom_range(8, 20);
            end
            if (!(k == 0 && $urandom_range(0, 11) == 0)) begin
                append_number(val, zeros);
            end
            if (k < 3) begin
                text_buf.push_back(ipdq_pkg::CHAR_DOT);
            end
        end
    endtask

    // Break an otherwise good address in one place.
    task automatic mutate_text();
        int unsigned pos;
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 4))
            0: text_buf.insert(pos, $urandom_range(0, 1) ? ipdq_pkg::CHAR_SPACE
                                                         : ipdq_pkg::CHAR_TAB);
            1: text_buf[pos] = 8'($urandom_range(0, 255));
            2: text_buf.insert(pos, ipdq_pkg::CHAR_DOT);
            3: text_buf.delete(pos);
            default: text_buf.push_back(ipdq_pkg::CHAR_DOT);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: build all stimulus, release reset, wait for the last
    // result, then report.
    // ------------------------------------------------------------------------
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.character = '0;
        in_ch.has_char  = 1'b0;
        in_ch.last      = 1'b0;
        out_ch.ready    = 1'b0;

        // Directed strings: empty, blank-only with an ignored transfer inside,
        // the byte extremes, an empty first octet, adjacent dots, a trailing
        // dot, and a good host closed by a transfer with no character.
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(ipdq_pkg::CHAR_SPACE, 1'b1, 1'b0);
        push_item(ipdq_pkg::CHAR_TAB, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);
        send_literal(".1.2.3", 1'b0);
        send_literal("1..2.3", 1'b0);
        send_literal("1.2.3.", 1'b0);
        send_literal("9.8.7.6", 1'b1);

        // Random strings: mostly well-formed addresses so that the octet and
        // reserved-range logic is exercised, the rest damaged text and noise.
        while (counted_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    repeat ($urandom_range(1, 6)) begin
                        text_buf.push_back(8'($urandom_range(0, 255)));
                    end
                end
                2: begin
                    repeat ($urandom_range(0, 4)) begin
                        text_buf.push_back($urandom_range(0, 1) ? ipdq_pkg::CHAR_SPACE
                                                                : ipdq_pkg::CHAR_TAB);
                    end
                end
                3: begin
                    repeat ($urandom_range(1, 12)) begin
                        text_buf.push_back(($urandom_range(0, 10) == 10) ?
                                           ipdq_pkg::CHAR_DOT :
                                           ipdq_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                    end
                end
                4, 5, 6, 7, 8: begin
                    build_address();
                    mutate_text();
                end
                default: build_address();
            endcase
            send_text($urandom_range(0, 9) == 0);
        end

        // Synchronous reset held low at start, then released once on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sampled on the falling edge so that everything from the preceding
        // rising edge has settled. Every queued string must come back.
        do begin
            @(negedge clk);
        end while (results_seen < strings_built);

        // Further rising edges let any stray result show up.
        repeat (4) @(posedge clk);

        if (results_seen != strings_built || awaited_parses.size() != 0) begin
            report_mismatch("result count", results_seen, strings_built);
        end

        $display("Parsed %0d strings from %0d character transfers: %0d ok, %0d malformed,",
                 results_seen, chars_taken, status_seen[ipdq_pkg::ST_OK],
                 status_seen[ipdq_pkg::ST_MALFORMED]);
        $display("%0d empty, %0d reserved; input stalled by back-pressure on %0d cycles.",
                 status_seen[ipdq_pkg::ST_EMPTY], status_seen[ipdq_pkg::ST_RESERVED],
                 input_backpressure);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender: presents queued transfers on the falling edge, in bursts of
    // random length separated by random gaps. A transfer that was not taken
    // is held unchanged.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_took) begin
            // Still waiting on ready; keep the transfer steady.
        end else if (gap_left > 0) begin
            gap_left    <= gap_left - 1;
            in_ch.valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
            next_item       = pending_chars.pop_front();
            in_ch.valid     <= 1'b1;
            in_ch.character <= next_item.ch;
            in_ch.has_char  <= next_item.has_char;
            in_ch.last      <= next_item.last;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(0, 4) == 0 ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 16);
                gap_left   <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: at regular intervals it picks a new stall pattern (always
    // ready, one stall in four, alternating ready and stall runs, or coin
    // flips). The forced hold-off below overrides the pattern.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 48 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        if (long_hold) begin
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= (rx_cycle % 4) != 0;
                2: out_ch.ready <= ((rx_cycle / 4) % 2) != 0;
                default: out_ch.ready <= 1'b1 & $urandom_range(0, 1);
            endcase
        end
    end

    // Once traffic is flowing, the receiver refuses results for a long
    // stretch while the sender keeps going, so the output register and the
    // skid entry both fill and the parser has to drop its input ready.
    initial begin
        long_hold = 1'b0;
        wait (chars_taken >= 150);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: on each rising edge, feed an accepted character to the
    // predictor and compare an accepted result with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        in_took <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                chars_taken++;
                parse_char(t_char_item'{in_ch.character, in_ch.has_char, in_ch.last},
                           parse_done, predicted);
                if (parse_done) begin
                    awaited_parses.push_back(predicted);
                end
            end else if (in_ch.valid) begin
                input_backpressure++;
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                status_seen[out_ch.status]++;
                if (awaited_parses.size() == 0) begin
                    report_mismatch("result with no string pending", out_ch.address, '0);
                end else begin
                    want = awaited_parses.pop_front();
                    if (out_ch.status !== want.status) begin
                        report_mismatch("status", 32'(out_ch.status), 32'(want.status));
                    end
                    if (out_ch.address !== want.address) begin
                        report_mismatch("address", out_ch.address, want.address);
                    end
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means
    // the block has hung.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("Timed out after %0d cycles without a transfer", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

`default_nettype wire
